@@ rtl/afm_pkg.sv @@
// types and constants of the adaptive frequency model
// no dependencies
`default_nettype none
package afm_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INC    = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  symbol;
    logic [15:0] target_value;
  } afm_in_t;

  typedef struct packed {
    logic [7:0]  found_symbol;
    logic [15:0] cum_low;
    logic [15:0] sym_count;
    logic [16:0] total_count;
    logic        error;
  } afm_out_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DONE,
    ST_LK_MAP, ST_LK_POS, ST_LK_SELF, ST_LK_UP,
    ST_FD_RD, ST_FD_CHK,
    ST_IN_MAP, ST_IN_POS, ST_IN_CUR, ST_IN_PREV, ST_IN_BS, ST_IN_BSC,
    ST_IN_OTH, ST_IN_SW2, ST_IN_BUMP, ST_IN_CLIMB, ST_IN_LWR,
    ST_RB_A, ST_RB_B, ST_RB_C
  } afm_state_t;

endpackage
`default_nettype wire

@@ rtl/adaptive_frequency_model_core.sv @@
// adaptive frequency model top level: sequencer and state memories
// depends on afm_pkg and afm_ram
`default_nettype none
// One command at a time: start is taken while busy is low, and the single result appears on
// result for one cycle with done high; the receiver cannot stall it. The symbol tables sit in
// synchronous memories read one entry per cycle, so the work follows the tree depth
// D = clog2(NUM_SYMBOLS): a lookup reads the symbol map and climbs the tree, a find walks
// down it, and an increment adds a symbol map read, a binary search, the swap and a
// climb. When the total reaches max_total (clamped to 2..65536), a rescale pass halves the
// counts and rebuilds the tree. After reset a clearing pass over all NUM_SYMBOLS entries
// keeps busy high. The max_total register is written whenever
// cfg_valid is high; cfg_ready is always high.
module adaptive_frequency_model_core #(
  parameter int NUM_SYMBOLS = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [16:0]      cfg_data,
  input  wire logic             start,
  input  wire afm_pkg::afm_in_t cmd,
  output logic                  busy,
  output logic                  done,
  output afm_pkg::afm_out_t     result
);
  import afm_pkg::*;

  localparam int PW = $clog2(NUM_SYMBOLS);
  localparam int CW = PW + 2;

  afm_state_t st, st_next;

  logic [7:0]    sym_r;
  logic [15:0]   val_r;
  logic [PW-1:0] p, lo, hi, mid, other, idx;
  logic          add_f;
  logic [16:0]   lc, c, acc, total, max_total;
  logic [7:0]    fsym;
  logic          err;

  logic          cnt_we, left_we, sub_we, s2p_we, p2s_we;
  logic [PW-1:0] cnt_wa, left_wa, sub_wa, s2p_wa, p2s_wa;
  logic [PW-1:0] cnt_ra, left_ra, sub_ra, s2p_ra, p2s_ra;
  logic [16:0]   cnt_wd, left_wd, sub_wd, cnt_rd, left_rd, sub_rd;
  logic [PW-1:0] s2p_wd, p2s_wd, s2p_rd, p2s_rd;

  afm_ram #(.WIDTH(17), .DEPTH(NUM_SYMBOLS)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  afm_ram #(.WIDTH(17), .DEPTH(NUM_SYMBOLS)) u_left (
    .clk(clk), .we(left_we), .waddr(left_wa), .wdata(left_wd), .raddr(left_ra),
    .rdata(left_rd));
  afm_ram #(.WIDTH(17), .DEPTH(NUM_SYMBOLS)) u_sub (
    .clk(clk), .we(sub_we), .waddr(sub_wa), .wdata(sub_wd), .raddr(sub_ra), .rdata(sub_rd));
  afm_ram #(.WIDTH(PW), .DEPTH(NUM_SYMBOLS)) u_s2p (
    .clk(clk), .we(s2p_we), .waddr(s2p_wa), .wdata(s2p_wd), .raddr(s2p_ra), .rdata(s2p_rd));
  afm_ram #(.WIDTH(PW), .DEPTH(NUM_SYMBOLS)) u_p2s (
    .clk(clk), .we(p2s_we), .waddr(p2s_wa), .wdata(p2s_wd), .raddr(p2s_ra), .rdata(p2s_rd));

  logic [PW-1:0] up_p, sym_pos, last_idx;
  logic [PW:0]   lohi;
  logic [16:0]   lim, halved, hv, sr;
  logic [17:0]   base;
  logic [18:0]   top_sum;
  logic          go_left, go_right, child_ok, lch_ok, rch_ok, in_sym_ok, in_find_err;
  logic [CW-1:0] child, lch, rch;

  assign up_p      = (p - PW'(1)) >> 1;
  assign sym_pos   = PW'(sym_r);
  assign last_idx  = PW'(NUM_SYMBOLS - 1);
  assign lohi      = {1'b0, lo} + {1'b0, hi};
  assign lim       = (max_total < 17'd2) ? 17'd2 :
                     ((max_total > 17'd65536) ? 17'd65536 : max_total);
  assign hv        = cnt_rd >> 1;
  assign halved    = (cnt_rd == '0) ? '0 : ((hv == '0) ? 17'd1 : hv);
  assign base      = {1'b0, acc} + {1'b0, left_rd};
  assign top_sum   = {1'b0, base} + {2'b0, cnt_rd};
  assign go_left   = base > {2'b0, val_r};
  assign go_right  = top_sum <= {3'b0, val_r};
  assign child     = {1'b0, p, 1'b0} + (go_left ? CW'(1) : CW'(2));
  assign child_ok  = child < CW'(NUM_SYMBOLS);
  assign lch       = {1'b0, idx, 1'b0} + CW'(1);
  assign rch       = {1'b0, idx, 1'b0} + CW'(2);
  assign lch_ok    = lch < CW'(NUM_SYMBOLS);
  assign rch_ok    = rch < CW'(NUM_SYMBOLS);
  assign sr        = rch_ok ? sub_rd : '0;
  assign in_sym_ok = 32'(cmd.symbol) < NUM_SYMBOLS;
  assign in_find_err = {1'b0, cmd.target_value} >= total;

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR:   st_next = (idx == last_idx) ? ST_IDLE : ST_CLEAR;
      ST_IDLE: begin
        if (start) begin
          if (cmd.operation == OP_FIND) begin
            st_next = in_find_err ? ST_DONE : ST_FD_RD;
          end else if (!in_sym_ok) begin
            st_next = ST_DONE;
          end else if (cmd.operation == OP_INC) begin
            st_next = ST_IN_MAP;
          end else begin
            st_next = ST_LK_MAP;
          end
        end
      end
      ST_DONE:    st_next = ST_IDLE;
      ST_LK_MAP:  st_next = ST_LK_POS;
      ST_LK_POS:  st_next = ST_LK_SELF;
      ST_LK_SELF, ST_LK_UP: st_next = (p == '0) ? ST_DONE : ST_LK_UP;
      ST_FD_RD:   st_next = ST_FD_CHK;
      ST_FD_CHK: begin
        if (!go_left && !go_right) begin
          st_next = ST_DONE;
        end else begin
          st_next = child_ok ? ST_FD_RD : ST_DONE;
        end
      end
      ST_IN_MAP:  st_next = ST_IN_POS;
      ST_IN_POS:  st_next = ST_IN_CUR;
      ST_IN_CUR:  st_next = (p == '0) ? ST_IN_BUMP : ST_IN_PREV;
      ST_IN_PREV: st_next = (cnt_rd > c) ? ST_IN_BUMP : ST_IN_BS;
      ST_IN_BS:   st_next = (lo == hi) ? ST_IN_OTH : ST_IN_BSC;
      ST_IN_BSC:  st_next = ST_IN_BS;
      ST_IN_OTH:  st_next = ST_IN_SW2;
      ST_IN_SW2:  st_next = ST_IN_BUMP;
      ST_IN_BUMP: st_next = ST_IN_CLIMB;
      ST_IN_CLIMB: begin
        if (p == '0) begin
          st_next = (total >= lim) ? ST_RB_A : ST_LK_MAP;
        end else begin
          st_next = p[0] ? ST_IN_LWR : ST_IN_CLIMB;
        end
      end
      ST_IN_LWR:  st_next = ST_IN_CLIMB;
      ST_RB_A:    st_next = ST_RB_B;
      ST_RB_B:    st_next = ST_RB_C;
      ST_RB_C:    st_next = (idx == '0) ? ST_LK_MAP : ST_RB_A;
      default:    st_next = ST_IDLE;
    endcase
  end

  // memory controls and port outputs
  always_comb begin
    cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
    left_we = 1'b0; left_wa = '0; left_wd = '0; left_ra = '0;
    sub_we = 1'b0; sub_wa = '0; sub_wd = '0; sub_ra = '0;
    s2p_we = 1'b0; s2p_wa = '0; s2p_wd = '0; s2p_ra = '0;
    p2s_we = 1'b0; p2s_wa = '0; p2s_wd = '0; p2s_ra = '0;
    busy = (st != ST_IDLE);
    done = (st == ST_DONE);
    unique case (st)
      ST_CLEAR: begin
        cnt_we = 1'b1;  cnt_wa = idx;
        left_we = 1'b1; left_wa = idx;
        s2p_we = 1'b1;  s2p_wa = idx; s2p_wd = idx;
        p2s_we = 1'b1;  p2s_wa = idx; p2s_wd = idx;
      end
      ST_LK_MAP, ST_IN_MAP: s2p_ra = sym_pos;
      ST_LK_POS: begin
        cnt_ra = s2p_rd; left_ra = s2p_rd;
      end
      ST_LK_SELF, ST_LK_UP: begin
        cnt_ra = up_p; left_ra = up_p;
      end
      ST_FD_RD: begin
        cnt_ra = p; left_ra = p; p2s_ra = p;
      end
      ST_IN_POS:  cnt_ra = s2p_rd;
      ST_IN_CUR:  cnt_ra = p - PW'(1);
      ST_IN_BS: begin
        cnt_ra = lohi[PW:1];
        p2s_ra = hi;
      end
      ST_IN_OTH: begin
        s2p_we = 1'b1; s2p_wa = sym_pos; s2p_wd = hi;
        p2s_we = 1'b1; p2s_wa = p;       p2s_wd = p2s_rd;
      end
      ST_IN_SW2: begin
        s2p_we = 1'b1; s2p_wa = other; s2p_wd = p;
        p2s_we = 1'b1; p2s_wa = hi;    p2s_wd = sym_pos;
      end
      ST_IN_BUMP: begin
        cnt_we = 1'b1; cnt_wa = hi; cnt_wd = c + 17'd1;
      end
      ST_IN_CLIMB: left_ra = up_p;
      ST_IN_LWR: begin
        left_we = 1'b1; left_wa = p; left_wd = left_rd + 17'd1;
      end
      ST_RB_A: begin
        cnt_ra = idx; sub_ra = lch[PW-1:0];
      end
      ST_RB_B: sub_ra = rch[PW-1:0];
      ST_RB_C: begin
        cnt_we = 1'b1;  cnt_wa = idx;  cnt_wd = c;
        left_we = 1'b1; left_wa = idx; left_wd = lc;
        sub_we = 1'b1;  sub_wa = idx;  sub_wd = 17'(c + lc + sr);
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready           = 1'b1;
  assign result.found_symbol = fsym;
  assign result.cum_low      = lc[15:0];
  assign result.sym_count    = c[15:0];
  assign result.total_count  = total;
  assign result.error        = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      idx       <= '0;
      total     <= '0;
      max_total <= 17'd16384;
    end else begin
      st <= st_next;
      if (cfg_valid) begin
        max_total <= cfg_data;
      end
      case (st)
        ST_CLEAR: idx <= idx + PW'(1);
        ST_IDLE: begin
          sym_r <= cmd.symbol;
          val_r <= cmd.target_value;
          fsym  <= cmd.symbol;
          err   <= (cmd.operation == OP_FIND) && in_find_err;
          lc    <= '0;
          c     <= '0;
          acc   <= '0;
          p     <= '0;
        end
        ST_LK_POS, ST_IN_POS: p <= s2p_rd;
        ST_LK_SELF, ST_LK_UP: begin
          if (st == ST_LK_SELF) begin
            lc <= left_rd;
            c  <= cnt_rd;
          end else if (add_f) begin
            lc <= 17'(lc + left_rd + cnt_rd);
          end
          if (p != '0) begin
            add_f <= ~p[0];
            p     <= up_p;
          end
        end
        ST_FD_CHK: begin
          if (!go_left && !go_right) begin
            fsym <= 8'(p2s_rd);
            lc   <= 17'(base);
            c    <= cnt_rd;
          end else begin
            if (go_right) begin
              acc <= 17'(top_sum);
            end
            if (child_ok) begin
              p <= child[PW-1:0];
            end else begin
              err <= 1'b1;
            end
          end
        end
        ST_IN_CUR: begin
          c  <= cnt_rd;
          hi <= p;
        end
        ST_IN_PREV: lo <= '0;
        ST_IN_BS:   mid <= lohi[PW:1];
        ST_IN_BSC: begin
          if (cnt_rd > c) begin
            lo <= mid + PW'(1);
          end else begin
            hi <= mid;
          end
        end
        ST_IN_OTH:  other <= p2s_rd;
        ST_IN_BUMP: begin
          total <= 17'(total + 17'd1);
          p     <= hi;
        end
        ST_IN_CLIMB: begin
          if (p == '0) begin
            if (total >= lim) begin
              total <= '0;
              idx   <= last_idx;
            end
          end else begin
            p <= up_p;
          end
        end
        ST_RB_B: begin
          c  <= halved;
          lc <= lch_ok ? sub_rd : '0;
        end
        ST_RB_C: begin
          total <= 17'(total + c);
          idx   <= idx - PW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/afm_ram.sv @@
// single port write, single port read synchronous memory
// no dependencies
`default_nettype none
module afm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/afm_chk.sv @@
// port checker for the adaptive frequency model and its bind
// depends on afm_pkg and adaptive_frequency_model_core
`default_nettype none
module afm_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire afm_pkg::afm_out_t result
);
  import afm_pkg::*;

  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command beat taken but busy stayed low");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat longer than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.error) |-> (result.cum_low == '0 && result.sym_count == '0))
    else $error("error beat carries nonzero counts");

endmodule

bind adaptive_frequency_model_core afm_chk u_afm_chk (.*);
`default_nettype wire

@@ verif/tb.sv @@
// testbench for adaptive_frequency_model_core: directed and random commands
// with an in-bench frequency model predictor; depends on afm_pkg and the rtl
`timescale 1ns / 100ps
module tb;
  import afm_pkg::*;

  localparam int NSYM = 256;
  localparam int LIMIT_CYCLES = 8000000;

  typedef bit bool_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] cfg_data = '0;
  logic start = 1'b0;
  afm_in_t cmd = '0;
  logic busy, done;
  afm_out_t result;

  adaptive_frequency_model_core #(.NUM_SYMBOLS(NSYM)) u_top (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .start(start), .cmd(cmd), .busy(busy),
    .done(done), .result(result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  int unsigned cnt_at[NSYM];
  int unsigned left_sum[NSYM];
  int unsigned pos_of[NSYM];
  int unsigned sym_at[NSYM];
  int unsigned freq_total;
  int unsigned max_total_reg;

  afm_in_t pending_cmds[$];
  afm_out_t expected_results[$];
  int errors = 0;
  int beats_seen = 0;
  int cycle_count = 0;
  int gap_left = 0;
  bool_t hold_off;

  function automatic int unsigned clamp_limit();
    if (max_total_reg < 2) return 2;
    if (max_total_reg > 65536) return 65536;
    return max_total_reg;
  endfunction

  function automatic void model_clear();
    for (int i = 0; i < NSYM; i++) begin
      cnt_at[i] = 0;
      left_sum[i] = 0;
      pos_of[i] = i;
      sym_at[i] = i;
    end
    freq_total = 0;
    max_total_reg = 16384;
  endfunction

  function automatic int unsigned low_at(int unsigned p);
    int unsigned lc, up;
    lc = left_sum[p];
    while (p > 0) begin
      up = (p - 1) >> 1;
      if (p == 2 * up + 2) lc += left_sum[up] + cnt_at[up];
      p = up;
    end
    return lc;
  endfunction

  function automatic void bump_symbol(int unsigned s);
    int unsigned p, c, lo, hi, mid, other, up;
    p = pos_of[s];
    if (p != 0 && cnt_at[p - 1] <= cnt_at[p]) begin
      c = cnt_at[p];
      lo = 0;
      hi = p;
      while (lo != hi) begin
        mid = (lo + hi) >> 1;
        if (cnt_at[mid] > c) lo = mid + 1;
        else hi = mid;
      end
      other = sym_at[hi];
      pos_of[s] = hi;
      sym_at[p] = other;
      pos_of[other] = p;
      sym_at[hi] = s;
    end
    p = pos_of[s];
    cnt_at[p]++;
    freq_total++;
    while (p > 0) begin
      up = (p - 1) >> 1;
      if (p == 2 * up + 1) left_sum[up]++;
      p = up;
    end
    if (freq_total >= clamp_limit()) begin
      freq_total = 0;
      for (int i = 0; i < NSYM; i++) begin
        if (cnt_at[i] != 0) begin
          cnt_at[i] = cnt_at[i] >> 1;
          if (cnt_at[i] == 0) cnt_at[i] = 1;
          freq_total += cnt_at[i];
        end
      end
      for (int i = 0; i < NSYM; i++) left_sum[i] = 0;
      for (int i = NSYM - 1; i > 0; i--) begin
        p = i;
        while (p > 0) begin
          up = (p - 1) >> 1;
          if (p == 2 * up + 1) left_sum[up] += cnt_at[i];
          p = up;
        end
      end
    end
  endfunction

  function automatic afm_out_t predict_command(afm_in_t c);
    afm_out_t r;
    int unsigned p, base, acc, v;
    bit hit;
    r = '0;
    r.found_symbol = c.symbol;
    v = 32'(c.target_value);
    if (c.operation == OP_FIND) begin
      if (v >= freq_total) begin
        r.error = 1'b1;
      end else begin
        p = 0;
        acc = 0;
        hit = 1'b0;
        while (!hit && p < NSYM) begin
          base = acc + left_sum[p];
          if (base > v) begin
            p = 2 * p + 1;
          end else if (v >= base + cnt_at[p]) begin
            acc = base + cnt_at[p];
            p = 2 * p + 2;
          end else begin
            r.found_symbol = 8'(sym_at[p]);
            r.cum_low = 16'(base);
            r.sym_count = 16'(cnt_at[p]);
            hit = 1'b1;
          end
        end
        if (!hit) r.error = 1'b1;
      end
    end else begin
      if (c.operation == OP_INC) bump_symbol(32'(c.symbol));
      p = pos_of[c.symbol];
      r.cum_low = 16'(low_at(p));
      r.sym_count = 16'(cnt_at[p]);
    end
    r.total_count = 17'(freq_total);
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && start && !busy) begin
      expected_results.push_back(predict_command(cmd));
    end
  end

  bit accepted_now;
  always @(posedge clk) accepted_now <= !rst && start && !busy;

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted_now) void'(pending_cmds.pop_front());
      if (hold_off || pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (start && !accepted_now) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 30);
        else if ($urandom_range(0, 3) == 0) gap_left <= 0;
        start <= 1'b1;
        cmd <= pending_cmds[0];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    afm_out_t want;
    if (!rst && done) begin
      beats_seen <= beats_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation: %p", result);
        errors = errors + 1;
      end else begin
        want = expected_results.pop_front();
        if (result.found_symbol !== want.found_symbol) begin
          $error("found_symbol exp %0d got %0d", want.found_symbol, result.found_symbol);
          errors = errors + 1;
        end
        if (result.cum_low !== want.cum_low) begin
          $error("cum_low exp %0d got %0d", want.cum_low, result.cum_low);
          errors = errors + 1;
        end
        if (result.sym_count !== want.sym_count) begin
          $error("sym_count exp %0d got %0d", want.sym_count, result.sym_count);
          errors = errors + 1;
        end
        if (result.total_count !== want.total_count) begin
          $error("total_count exp %0d got %0d", want.total_count, result.total_count);
          errors = errors + 1;
        end
        if (result.error !== want.error) begin
          $error("error exp %0d got %0d", want.error, result.error);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic afm_in_t make_cmd(logic [1:0] op, logic [7:0] s, logic [15:0] v);
    afm_in_t c;
    c.operation = op;
    c.symbol = s;
    c.target_value = v;
    return c;
  endfunction

  // hot symbols make the sorted order and rescale paths busy
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 11) * 21);
  endfunction

  function automatic afm_in_t random_cmd();
    int unsigned k;
    logic [15:0] v;
    k = $urandom_range(0, 19);
    if (k < 1 || freq_total == 0) v = 16'($urandom);
    else v = 16'($urandom_range(0, freq_total));
    if (k < 10) return make_cmd(OP_INC, pick_symbol(), 16'($urandom));
    if (k < 15) return make_cmd(OP_FIND, pick_symbol(), v);
    if (k < 19) return make_cmd(OP_LOOKUP, pick_symbol(), 16'($urandom));
    return make_cmd(OP_UNUSED, 8'($urandom), 16'($urandom));
  endfunction

  task automatic drain_and_settle();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || start)
      @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_total_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
    drain_and_settle();
  endtask

  initial begin
    hold_off = 1'b0;
    model_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // empty model: find errors, lookups of zero counts, an unused op code, then increments and finds
    pending_cmds.push_back(make_cmd(OP_FIND, 8'd7, 16'd0));
    pending_cmds.push_back(make_cmd(OP_FIND, 8'hff, 16'hffff));
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 8'd0, 16'd0));
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 8'hff, 16'hffff));
    pending_cmds.push_back(make_cmd(OP_UNUSED, 8'h55, 16'haaaa));
    pending_cmds.push_back(make_cmd(OP_INC, 8'hff, 16'd0));
    pending_cmds.push_back(make_cmd(OP_INC, 8'd0, 16'hffff));
    pending_cmds.push_back(make_cmd(OP_INC, 8'd128, 16'd0));
    pending_cmds.push_back(make_cmd(OP_INC, 8'd128, 16'd0));
    pending_cmds.push_back(make_cmd(OP_INC, 8'd3, 16'd0));
    pending_cmds.push_back(make_cmd(OP_FIND, 8'd1, 16'd0));
    pending_cmds.push_back(make_cmd(OP_FIND, 8'd1, 16'd2));
    pending_cmds.push_back(make_cmd(OP_FIND, 8'd1, 16'd4));
    pending_cmds.push_back(make_cmd(OP_FIND, 8'd1, 16'd5));
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 8'd128, 16'd0));
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 8'd3, 16'd0));
    drain_and_settle();
    // limits below the floor and just above it: frequent halving
    write_limit(17'd0);
    run_random(150);
    write_limit(17'd1);
    run_random(100);
    write_limit(17'd5);
    run_random(150);
    // hold_off is raised and dropped again at once around one queued increment
    hold_off = 1'b1;
    pending_cmds.push_back(make_cmd(OP_INC, 8'd9, 16'd0));
    hold_off = 1'b0;
    drain_and_settle();
    write_limit(17'd40);
    run_random(300);
    write_limit(17'h1ffff);
    run_random(300);
    write_limit(17'd65536);
    run_random(200);
    write_limit(17'd300);
    run_random(400);
    repeat (50) @(posedge clk);
    $display("covered lookup, increment, find and unused op codes with %0d result beats",
             beats_seen);
    $display("max_total swept from below the floor to above the ceiling");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
